FILE: sv/fnvlp_pkg.sv
package fnvlp_pkg;

    localparam int SLOTS   = 64;
    localparam int MAX_KEY = 128;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int KIDX_W  = $clog2(MAX_KEY);
    localparam int LEN_W   = KIDX_W + 1;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [7:0]  COLON     = 8'h3a;
    localparam logic [7:0]  CASE_BIT  = 8'h20;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_BADKEY   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0] mode;
        logic       part;
        logic [7:0] key_byte;
        logic       last;
        logic [7:0] entry_type;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  found_type;
        logic [5:0]  slot_index;
        logic [31:0] name_hash;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_EVAL,
        S_PROBE_I,
        S_COPY,
        S_PROBE_L,
        S_CHK,
        S_BRD,
        S_BCMP,
        S_DONE
    } state_t;

endpackage

FILE: sv/fnvlp_hasher.sv
module fnvlp_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        init,
    input  logic        push,
    input  logic [7:0]  data,
    output logic [31:0] hash
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] mixed;

    assign mixed = hash_reg ^ {24'd0, data};

    always_comb begin
        hash_next = hash_reg;
        if (init) begin
            hash_next = fnvlp_pkg::FNV_BASIS;
        end else if (push) begin
            hash_next = mixed * fnvlp_pkg::FNV_PRIME;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= fnvlp_pkg::FNV_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

FILE: sv/fnv1a_linear_probe_key_table.sv
// Key table with FNV-1a hashing and linear probing over 64 slots.
// s_ channel: one key byte per transfer (mode, part, key_byte, last,
// entry_type). Clear (mode 2) empties the table and drops the staged key;
// mode 3 is taken and ignored. m_ channel: one result per last byte or clear.
// Each key byte is hashed and staged one canonical byte per step (up to three
// with a "::" separator pair), and s_ready is low meanwhile.
// On the last byte the key is evaluated; then insert probes slots until one is
// free and copies the key bytes into it, while lookup reads each probed slot
// and compares the key bytes on a hash and length hit. The result register is
// loaded last. A clear goes straight to loading the result register.
// The one hash multiplier is shared by key bytes and separators; the block
// works on one byte at a time.
// Reset (aresetn, synchronous, active low) empties the table through per-slot
// valid bits at once; no clearing pass is needed.
// The result sits in an output register; the block keeps taking key bytes
// while it waits. A result that finds the register still held by a stalled
// receiver waits in the final state until that transfer completes.
module fnv1a_linear_probe_key_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fnvlp_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fnvlp_pkg::out_t   m_data
);

    localparam int SW = fnvlp_pkg::SLOT_W;
    localparam int KW = fnvlp_pkg::KIDX_W;
    localparam int LW = fnvlp_pkg::LEN_W;

    fnvlp_pkg::state_t state_reg, state_next;

    logic [4:0]           mask_reg, mask_next;   // pending pushes: ':' ':' byte ':' ':'
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [1:0]           mode_reg, mode_next;
    logic [7:0]           etype_reg, etype_next;
    logic                 cls_reg, cls_next;
    logic                 fn_reg, fn_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [SW-1:0]        n_reg, n_next;
    logic [KW-1:0]        idx_reg, idx_next;
    logic [2:0]           status_reg, status_next;
    logic [fnvlp_pkg::SLOTS-1:0] occ_reg, occ_next;
    logic                 cp_wv_reg;
    logic [KW-1:0]        cp_waddr_reg;
    logic                 m_valid_reg, m_valid_next;
    fnvlp_pkg::out_t      m_data_reg, m_data_next;

    // hash unit control
    logic        h_init, h_push;
    logic [7:0]  pbyte;
    logic [31:0] hash;

    // memories
    logic [7:0]  sk_mem [fnvlp_pkg::MAX_KEY];
    logic [7:0]  kb_mem [fnvlp_pkg::SLOTS * fnvlp_pkg::MAX_KEY];
    logic [31:0] hash_mem [fnvlp_pkg::SLOTS];
    logic [KW-1:0] klen_mem [fnvlp_pkg::SLOTS];
    logic [7:0]  type_mem [fnvlp_pkg::SLOTS];
    logic [7:0]  sk_rd_reg, kb_rd_reg, type_rd_reg;
    logic [31:0] hash_rd_reg;
    logic [KW-1:0] klen_rd_reg;

    logic          sk_we, slot_we;
    logic [SW-1:0] slot;
    logic [KW-1:0] len_m1;
    logic          acc, out_free;
    logic          pre_sep, post_sep, cls_acc, fn_acc;
    logic [7:0]    folded;
    logic          key_bad;

    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign slot     = hash[SW-1:0] + n_reg;
    assign len_m1   = len_reg[KW-1:0] - KW'(1);
    assign key_bad  = (len_reg == '0) || (len_reg >= LW'(fnvlp_pkg::MAX_KEY));

    // canonical byte sequence for the incoming transfer
    assign folded   = (s_data.key_byte >= 8'h41 && s_data.key_byte <= 8'h5a)
                      ? (s_data.key_byte | fnvlp_pkg::CASE_BIT) : s_data.key_byte;
    assign pre_sep  = s_data.part && cls_reg && !fn_reg;
    assign cls_acc  = cls_reg || !s_data.part;
    assign fn_acc   = fn_reg || s_data.part;
    assign post_sep = s_data.last && cls_acc && !fn_acc;

    // lowest pending push goes first; bit 2 is the key byte itself
    assign pbyte = (mask_reg[1:0] == 2'b00) && mask_reg[2] ? byte_reg : fnvlp_pkg::COLON;

    fnvlp_hasher u_hasher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (h_init),
        .push    (h_push),
        .data    (pbyte),
        .hash    (hash)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fnvlp_pkg::S_IDLE: begin
                if (acc) begin
                    if (s_data.mode == fnvlp_pkg::MODE_CLEAR) begin
                        state_next = fnvlp_pkg::S_DONE;
                    end else if (s_data.mode != fnvlp_pkg::MODE_IGNORE) begin
                        state_next = fnvlp_pkg::S_PUSH;
                    end
                end
            end
            fnvlp_pkg::S_PUSH: begin
                if ((mask_reg & (mask_reg - 5'd1)) == 5'd0) begin
                    state_next = last_reg ? fnvlp_pkg::S_EVAL : fnvlp_pkg::S_IDLE;
                end
            end
            fnvlp_pkg::S_EVAL: begin
                if (key_bad) begin
                    state_next = fnvlp_pkg::S_DONE;
                end else if (mode_reg == fnvlp_pkg::MODE_INSERT) begin
                    state_next = fnvlp_pkg::S_PROBE_I;
                end else begin
                    state_next = fnvlp_pkg::S_PROBE_L;
                end
            end
            fnvlp_pkg::S_PROBE_I: begin
                if (!occ_reg[slot]) begin
                    state_next = fnvlp_pkg::S_COPY;
                end else if (n_reg == '1) begin
                    state_next = fnvlp_pkg::S_DONE;
                end
            end
            fnvlp_pkg::S_COPY: begin
                if (idx_reg == len_m1) begin
                    state_next = fnvlp_pkg::S_DONE;
                end
            end
            fnvlp_pkg::S_PROBE_L: begin
                state_next = occ_reg[slot] ? fnvlp_pkg::S_CHK : fnvlp_pkg::S_DONE;
            end
            fnvlp_pkg::S_CHK: begin
                if (hash_rd_reg == hash && klen_rd_reg == len_reg[KW-1:0]) begin
                    state_next = fnvlp_pkg::S_BRD;
                end else begin
                    state_next = (n_reg == '1) ? fnvlp_pkg::S_DONE : fnvlp_pkg::S_PROBE_L;
                end
            end
            fnvlp_pkg::S_BRD: begin
                state_next = fnvlp_pkg::S_BCMP;
            end
            fnvlp_pkg::S_BCMP: begin
                if (sk_rd_reg != kb_rd_reg) begin
                    state_next = (n_reg == '1) ? fnvlp_pkg::S_DONE : fnvlp_pkg::S_PROBE_L;
                end else if (idx_reg == len_m1) begin
                    state_next = fnvlp_pkg::S_DONE;
                end else begin
                    state_next = fnvlp_pkg::S_BRD;
                end
            end
            fnvlp_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = fnvlp_pkg::S_IDLE;
                end
            end
            default: state_next = fnvlp_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mask_next    = mask_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        mode_next    = mode_reg;
        etype_next   = etype_reg;
        cls_next     = cls_reg;
        fn_next      = fn_reg;
        len_next     = len_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        h_init       = 1'b0;
        h_push       = 1'b0;
        sk_we        = 1'b0;
        slot_we      = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            fnvlp_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (acc) begin
                    mode_next  = s_data.mode;
                    last_next  = s_data.last;
                    etype_next = s_data.entry_type;
                    byte_next  = folded;
                    if (s_data.mode == fnvlp_pkg::MODE_CLEAR) begin
                        occ_next    = '0;
                        status_next = fnvlp_pkg::ST_CLEARED;
                    end else if (s_data.mode != fnvlp_pkg::MODE_IGNORE) begin
                        cls_next  = cls_acc;
                        fn_next   = fn_acc;
                        mask_next = {post_sep, post_sep, 1'b1, pre_sep, pre_sep};
                    end
                end
            end
            fnvlp_pkg::S_PUSH: begin
                h_push    = 1'b1;
                mask_next = mask_reg & (mask_reg - 5'd1);
                if (len_reg < LW'(fnvlp_pkg::MAX_KEY)) begin
                    sk_we    = 1'b1;
                    len_next = len_reg + LW'(1);
                end
            end
            fnvlp_pkg::S_EVAL: begin
                n_next      = '0;
                idx_next    = '0;
                status_next = key_bad ? fnvlp_pkg::ST_BADKEY : fnvlp_pkg::ST_FULL;
            end
            fnvlp_pkg::S_PROBE_I: begin
                if (!occ_reg[slot]) begin
                    occ_next[slot] = 1'b1;
                    slot_we        = 1'b1;
                    status_next    = fnvlp_pkg::ST_INSERTED;
                end else begin
                    n_next = n_reg + SW'(1);
                end
            end
            fnvlp_pkg::S_COPY: begin
                idx_next = idx_reg + KW'(1);
            end
            fnvlp_pkg::S_PROBE_L: begin
                idx_next = '0;
                if (!occ_reg[slot]) begin
                    status_next = fnvlp_pkg::ST_MISS;
                end
            end
            fnvlp_pkg::S_CHK: begin
                if (!(hash_rd_reg == hash && klen_rd_reg == len_reg[KW-1:0])) begin
                    n_next = n_reg + SW'(1);
                end
            end
            fnvlp_pkg::S_BRD: begin
            end
            fnvlp_pkg::S_BCMP: begin
                if (sk_rd_reg != kb_rd_reg) begin
                    n_next = n_reg + SW'(1);
                end else if (idx_reg == len_m1) begin
                    status_next = fnvlp_pkg::ST_FOUND;
                end else begin
                    idx_next = idx_reg + KW'(1);
                end
            end
            fnvlp_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.found_type = (status_reg == fnvlp_pkg::ST_FOUND)
                                             ? type_rd_reg : 8'd0;
                    m_data_next.slot_index = (status_reg == fnvlp_pkg::ST_FOUND ||
                                              status_reg == fnvlp_pkg::ST_INSERTED)
                                             ? 6'(slot) : 6'd0;
                    m_data_next.name_hash  = (status_reg == fnvlp_pkg::ST_CLEARED)
                                             ? 32'd0 : hash;
                    // drop the staged key
                    h_init    = 1'b1;
                    len_next  = '0;
                    cls_next  = 1'b0;
                    fn_next   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fnvlp_pkg::S_IDLE;
            cls_reg     <= 1'b0;
            fn_reg      <= 1'b0;
            len_reg     <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
            cp_wv_reg   <= 1'b0;
            mask_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cls_reg     <= cls_next;
            fn_reg      <= fn_next;
            len_reg     <= len_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            cp_wv_reg   <= (state_reg == fnvlp_pkg::S_COPY);
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        mode_reg     <= mode_next;
        etype_reg    <= etype_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
        cp_waddr_reg <= idx_reg;
    end

    // staged key: written while pushing, read for copy and compare
    always_ff @(posedge aclk) begin
        if (sk_we) begin
            sk_mem[len_reg[KW-1:0]] <= pbyte;
        end
        sk_rd_reg <= sk_mem[idx_reg];
    end

    // slot key bytes: copy write lands in the cycle after the staged read
    always_ff @(posedge aclk) begin
        if (cp_wv_reg) begin
            kb_mem[{slot, cp_waddr_reg}] <= sk_rd_reg;
        end
        kb_rd_reg <= kb_mem[{slot, idx_reg}];
    end

    // per-slot hash, length and type
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            hash_mem[slot] <= hash;
            klen_mem[slot] <= len_reg[KW-1:0];
            type_mem[slot] <= etype_reg;
        end
        hash_rd_reg <= hash_mem[slot];
        klen_rd_reg <= klen_mem[slot];
        type_rd_reg <= type_mem[slot];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sim/fnv1a_linear_probe_key_table_test.sv
module fnv1a_linear_probe_key_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 100000;

    // Model state of the key table
    class key_table_scoreboard;
        byte unsigned stage_bytes[fnvlp_pkg::MAX_KEY];
        int unsigned  stage_len;
        logic [31:0]  hash_acc;
        bit           saw_class;
        bit           saw_func;
        bit           occupied[fnvlp_pkg::SLOTS];
        logic [31:0]  tab_hash[fnvlp_pkg::SLOTS];
        logic [7:0]   tab_type[fnvlp_pkg::SLOTS];
        int unsigned  tab_len[fnvlp_pkg::SLOTS];
        byte unsigned tab_bytes[fnvlp_pkg::SLOTS][fnvlp_pkg::MAX_KEY];
        fnvlp_pkg::out_t pending[$];
        int           mismatches;
        int           results_seen;
        int           hist[8];

        function void drop_stage();
            stage_len = 0;
            hash_acc  = fnvlp_pkg::FNV_BASIS;
            saw_class = 0;
            saw_func  = 0;
        endfunction

        function void wipe();
            foreach (occupied[i]) occupied[i] = 0;
            drop_stage();
        endfunction

        function void stage_byte(byte unsigned c);
            hash_acc = (hash_acc ^ {24'd0, c}) * fnvlp_pkg::FNV_PRIME;
            if (stage_len < fnvlp_pkg::MAX_KEY) begin
                stage_bytes[stage_len] = c;
                stage_len++;
            end
        endfunction

        function bit same_key(int s);
            if (tab_len[s] != stage_len) return 0;
            for (int k = 0; k < stage_len; k++)
                if (tab_bytes[s][k] != stage_bytes[k]) return 0;
            return 1;
        endfunction

        // Note an accepted input transfer and queue any result it causes
        function void note_input(fnvlp_pkg::in_t it);
            fnvlp_pkg::out_t r;
            int   s;
            byte unsigned c;
            if (it.mode == fnvlp_pkg::MODE_IGNORE) return;
            r = '0;
            if (it.mode == fnvlp_pkg::MODE_CLEAR) begin
                wipe();
                r.status = fnvlp_pkg::ST_CLEARED;
                pending.push_back(r);
                return;
            end
            if (it.part) begin
                if (saw_class && !saw_func) begin
                    stage_byte(fnvlp_pkg::COLON);
                    stage_byte(fnvlp_pkg::COLON);
                end
                saw_func = 1;
            end else begin
                saw_class = 1;
            end
            c = it.key_byte;
            if (c >= 8'h41 && c <= 8'h5a) c = c | fnvlp_pkg::CASE_BIT;
            stage_byte(c);
            if (!it.last) return;
            if (saw_class && !saw_func) begin
                stage_byte(fnvlp_pkg::COLON);
                stage_byte(fnvlp_pkg::COLON);
            end
            r.name_hash = hash_acc;
            if (stage_len == 0 || stage_len >= fnvlp_pkg::MAX_KEY) begin
                r.status = fnvlp_pkg::ST_BADKEY;
            end else if (it.mode == fnvlp_pkg::MODE_INSERT) begin
                r.status = fnvlp_pkg::ST_FULL;
                for (int n = 0; n < fnvlp_pkg::SLOTS; n++) begin
                    s = (hash_acc % fnvlp_pkg::SLOTS + n) % fnvlp_pkg::SLOTS;
                    if (!occupied[s]) begin
                        occupied[s] = 1;
                        tab_hash[s] = hash_acc;
                        tab_type[s] = it.entry_type;
                        tab_len[s]  = stage_len;
                        for (int k = 0; k < stage_len; k++)
                            tab_bytes[s][k] = stage_bytes[k];
                        r.slot_index = s[5:0];
                        r.status = fnvlp_pkg::ST_INSERTED;
                        break;
                    end
                end
            end else begin
                r.status = fnvlp_pkg::ST_FULL;
                for (int n = 0; n < fnvlp_pkg::SLOTS; n++) begin
                    s = (hash_acc % fnvlp_pkg::SLOTS + n) % fnvlp_pkg::SLOTS;
                    if (!occupied[s]) begin
                        r.status = fnvlp_pkg::ST_MISS;
                        break;
                    end
                    if (tab_hash[s] == hash_acc && same_key(s)) begin
                        r.status = fnvlp_pkg::ST_FOUND;
                        r.slot_index = s[5:0];
                        r.found_type = tab_type[s];
                        break;
                    end
                end
            end
            drop_stage();
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(fnvlp_pkg::out_t got);
            fnvlp_pkg::out_t want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            hist[want.status]++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    fnvlp_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    fnvlp_pkg::out_t m_data;

    key_table_scoreboard sb;
    int idle_cycles;
    int sent;
    bit done_sending;

    always #5 aclk = ~aclk;

    fnv1a_linear_probe_key_table i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Monitor: sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: random stall per result, with calm stretches
    initial begin
        int wait_n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_n > 0) begin
                m_ready <= 0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Send one transfer after a random gap if gaps is set; valid held until accepted.
    // Valid stays up after the transfer until the next call or a drain.
    task automatic send_byte(fnvlp_pkg::in_t it, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    function automatic fnvlp_pkg::in_t mk(logic [1:0] md, logic pt, logic [7:0] b,
                                          logic lst, logic [7:0] et);
        fnvlp_pkg::in_t it;
        it.mode = md; it.part = pt; it.key_byte = b; it.last = lst; it.entry_type = et;
        return it;
    endfunction

    // Key from a small alphabet so that lookups hit inserted keys
    task automatic send_key(logic [1:0] md, int cls_len, int fn_len, int seed,
                            logic [7:0] et, bit gaps);
        int total;
        byte unsigned ch;
        total = cls_len + fn_len;
        for (int k = 0; k < total; k++) begin
            ch = 8'h41 + ((seed * 7 + k * 3) % 6);
            if ((seed + k) & 1) ch = ch | fnvlp_pkg::CASE_BIT;
            send_byte(mk(md, k >= cls_len, ch, k == total - 1, et), gaps);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    initial begin
        bit gaps;
        int r, cl, fl;
        sb = new();
        sb.wipe();
        idle_cycles = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: field extremes, every mode, separator cases
        send_byte(mk(fnvlp_pkg::MODE_LOOKUP, 1'b1, 8'h41, 1'b1, 8'h00), 0); // miss, empty
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b1, 8'h5a, 1'b1, 8'hff), 0);
        send_byte(mk(fnvlp_pkg::MODE_LOOKUP, 1'b1, 8'h7a, 1'b1, 8'h00), 0); // folded hit
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b0, 8'hff, 1'b1, 8'h5a), 0); // class only
        send_byte(mk(fnvlp_pkg::MODE_LOOKUP, 1'b0, 8'hff, 1'b1, 8'h00), 0);
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b0, 8'h00, 1'b0, 8'h00), 0); // class, func
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b1, 8'h40, 1'b0, 8'h00), 0);
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b0, 8'h5b, 1'b1, 8'ha5), 0); // class late
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b1, 8'h5a, 1'b1, 8'h33), 0); // duplicate
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b1, 8'h61, 1'b0, 8'h00), 0); // mixed modes
        send_byte(mk(fnvlp_pkg::MODE_LOOKUP, 1'b1, 8'h62, 1'b1, 8'h00), 0);
        send_byte(mk(fnvlp_pkg::MODE_IGNORE, 1'b1, 8'hff, 1'b1, 8'hff), 0); // ignored
        send_key(fnvlp_pkg::MODE_INSERT, 0, 130, 1, 8'h11, 0);              // too long
        send_key(fnvlp_pkg::MODE_INSERT, 60, 65, 2, 8'h12, 0);              // MAX-1 bytes
        send_byte(mk(fnvlp_pkg::MODE_INSERT, 1'b0, 8'h41, 1'b0, 8'h00), 0); // dropped
        send_byte(mk(fnvlp_pkg::MODE_CLEAR, 1'b0, 8'h00, 1'b0, 8'h00), 0);
        send_byte(mk(fnvlp_pkg::MODE_LOOKUP, 1'b1, 8'h7a, 1'b1, 8'h00), 0);
        drain();

        // Fill the table to the brim, then probe full cases
        for (int i = 0; i < fnvlp_pkg::SLOTS + 2; i++)
            send_key(fnvlp_pkg::MODE_INSERT, 1, 2, i, i[7:0], 0);
        send_key(fnvlp_pkg::MODE_LOOKUP, 2, 2, 999, 8'h00, 0);
        send_key(fnvlp_pkg::MODE_LOOKUP, 1, 2, 5, 8'h00, 0);
        drain();
        send_byte(mk(fnvlp_pkg::MODE_CLEAR, 1'b1, 8'hff, 1'b1, 8'hff), 0);

        // Random: mostly well-formed keys over a small alphabet
        while (sent < 1750) begin
            gaps = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 2) begin
                send_byte(mk(fnvlp_pkg::MODE_CLEAR, $urandom, $urandom, $urandom,
                             $urandom), gaps);
            end else if (r < 10) begin
                send_byte(mk($urandom, $urandom, $urandom, $urandom, $urandom), gaps);
            end else if (r < 12) begin
                drain();                                   // sender holds off
            end else begin
                cl = $urandom_range(0, 3);
                fl = $urandom_range(cl == 0 ? 1 : 0, 4);
                send_key($urandom_range(0, 1), cl, fl, $urandom_range(0, 20),
                         $urandom, gaps);
            end
        end
        drain();

        $display("%0d transfers sent, %0d results checked", sent, sb.results_seen);
        $display("found %0d, miss %0d, inserted %0d, bad key %0d, full %0d, cleared %0d",
                 sb.hist[fnvlp_pkg::ST_FOUND], sb.hist[fnvlp_pkg::ST_MISS],
                 sb.hist[fnvlp_pkg::ST_INSERTED], sb.hist[fnvlp_pkg::ST_BADKEY],
                 sb.hist[fnvlp_pkg::ST_FULL], sb.hist[fnvlp_pkg::ST_CLEARED]);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: sim.f
sv/fnvlp_pkg.sv
sv/fnvlp_hasher.sv
sv/fnv1a_linear_probe_key_table.sv
sim/fnv1a_linear_probe_key_table_test.sv
